// ===== hdl/pscc_pkg.sv =====
`default_nettype none

package pscc_pkg;

	localparam int MAX_LEN = 1024;
	localparam int ADDR_W  = $clog2(MAX_LEN);
	localparam int LEN_W   = $clog2(MAX_LEN + 1);
	localparam int CNT_W   = 30;
	localparam int CHAR_W  = 8;

	localparam logic [CNT_W-1:0] PAL_MOD = CNT_W'(1000000007);

	typedef enum logic [2:0] {
		S_COLLECT,
		S_START,
		S_INIT,
		S_CELL,
		S_DRAIN,
		S_DONE,
		S_EMPTY
	} state_t;

	typedef struct packed {
		logic store_char;
		logic clear_len;
		logic start_row;
		logic row_init;
		logic cell_step;
		logic next_row;
		logic load_result;
		logic load_empty;
	} cmd_t;

	typedef struct packed {
		logic no_cells;
		logic last_cell;
		logic first_row;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

// ===== hdl/palindromic_subsequence_counter_core.sv =====
// Counts the palindromic subsequences (by position) of a byte string, modulo 1000000007.
// Send the characters one per transfer on the slave side with tlast on the final one, or a
// single transfer with tuser set for an empty string (answer 0). Up to 1024 characters are
// kept; later ones are dropped and the result carries tuser (overflow) set. After the last
// character the block works the interval recurrence one cell per cycle, set by the single
// read and write port of the row memory, and no character is taken until its result has
// been loaded. The result sits in an output register, so the next string may be sent while
// it waits to be taken.
`default_nettype none

module palindromic_subsequence_counter_core (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [7:0]  s_tdata,   // [7:0] char_byte
	input  wire         s_tlast,
	input  wire         s_tuser,   // [0] is_empty
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [31:0] m_tdata,   // [29:0] count, [31:30] zero
	output logic        m_tuser    // [0] overflow
);
	import pscc_pkg::*;

	cmd_t             cmd;
	sts_t             sts;
	logic [CNT_W-1:0] count;

	pscc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tlast  (s_tlast),
		.s_tuser  (s_tuser),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	pscc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.char_in   (s_tdata),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_count (count),
		.out_ovf   (m_tuser)
	);

	assign m_tdata = {2'b00, count};

endmodule

`default_nettype wire

// ===== hdl/pscc_ctrl.sv =====
`default_nettype none

module pscc_ctrl (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              s_tvalid,
	input  wire              s_tlast,
	input  wire              s_tuser,
	output logic             s_tready,
	input  pscc_pkg::sts_t   sts,
	output pscc_pkg::cmd_t   cmd
);
	import pscc_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_COLLECT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_COLLECT: begin
				if (s_tvalid) begin
					if (s_tuser) begin
						state_d = S_EMPTY;
					end else if (s_tlast) begin
						state_d = S_START;
					end
				end
			end
			S_START: state_d = S_INIT;
			S_INIT: begin
				state_d = sts.no_cells ? S_DRAIN : S_CELL;
			end
			S_CELL: begin
				if (sts.last_cell) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = sts.first_row ? S_DONE : S_INIT;
			end
			S_DONE: begin
				if (sts.out_free) begin
					state_d = S_COLLECT;
				end
			end
			S_EMPTY: begin
				if (sts.out_free) begin
					state_d = S_COLLECT;
				end
			end
			default: state_d = S_COLLECT;
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		cmd      = '0;
		case (state_q)
			S_COLLECT: begin
				s_tready       = 1'b1;
				cmd.store_char = s_tvalid && !s_tuser;
				cmd.clear_len  = s_tvalid && s_tuser;
			end
			S_START: cmd.start_row = 1'b1;
			S_INIT:  cmd.row_init  = 1'b1;
			S_CELL:  cmd.cell_step = 1'b1;
			S_DRAIN: cmd.next_row  = !sts.first_row;
			S_DONE:  cmd.load_result = sts.out_free;
			S_EMPTY: cmd.load_empty  = sts.out_free;
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== hdl/pscc_dp.sv =====
`default_nettype none

module pscc_dp (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire  [pscc_pkg::CHAR_W-1:0] char_in,
	input  pscc_pkg::cmd_t              cmd,
	output pscc_pkg::sts_t              sts,
	output logic                        out_valid,
	input  wire                         out_ready,
	output logic [pscc_pkg::CNT_W-1:0]  out_count,
	output logic                        out_ovf
);
	import pscc_pkg::*;

	logic [CHAR_W-1:0] char_mem [MAX_LEN];
	logic [CNT_W-1:0]  row_mem  [MAX_LEN];

	logic [LEN_W-1:0]  len_q;
	logic              ovf_q;
	logic [ADDR_W-1:0] i_q;
	logic [ADDR_W-1:0] j_q;
	logic [LEN_W-1:0]  len_m1;

	logic              cell_s1;
	logic              head_s1;
	logic [ADDR_W-1:0] j_s1;
	logic [CHAR_W-1:0] char_rd_s1;
	logic [CNT_W-1:0]  row_rd_s1;

	logic [CHAR_W-1:0] ci_q;
	logic [CNT_W-1:0]  left_q;
	logic [CNT_W-1:0]  inner_q;
	logic              out_valid_q;
	logic [CNT_W-1:0]  out_count_q;
	logic              out_ovf_q;

	logic [ADDR_W-1:0] char_rd_addr;
	logic              row_we;
	logic [ADDR_W-1:0] row_wr_addr;
	logic [CNT_W-1:0]  row_wr_data;
	logic [CNT_W:0]    sum_raw;
	logic [CNT_W-1:0]  sum_red;
	logic [CNT_W:0]    inc_raw;
	logic [CNT_W:0]    dif_raw;
	logic [CNT_W:0]    dif_fix;
	logic [CNT_W-1:0]  cell_val;

	assign len_m1 = len_q - LEN_W'(1);

	assign sts.no_cells  = ({1'b0, i_q} == len_m1);
	assign sts.last_cell = ({1'b0, j_q} == len_m1);
	assign sts.first_row = (i_q == '0);
	assign sts.out_free  = !out_valid_q || out_ready;

	// length and overflow of the string being collected
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			ovf_q <= 1'b0;
		end else if (cmd.clear_len || cmd.load_result) begin
			len_q <= '0;
			ovf_q <= 1'b0;
		end else if (cmd.store_char) begin
			if (len_q < LEN_W'(MAX_LEN)) begin
				len_q <= len_q + LEN_W'(1);
			end else begin
				ovf_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.store_char && len_q < LEN_W'(MAX_LEN)) begin
			char_mem[len_q[ADDR_W-1:0]] <= char_in;
		end
	end

	assign char_rd_addr = cmd.row_init ? i_q : j_q;

	always_ff @(posedge clk) begin
		char_rd_s1 <= char_mem[char_rd_addr];
		row_rd_s1  <= row_mem[j_q];
	end

	// row and column walk
	always_ff @(posedge clk) begin
		if (cmd.start_row) begin
			i_q <= len_m1[ADDR_W-1:0];
		end else if (cmd.next_row) begin
			i_q <= i_q - ADDR_W'(1);
		end
		if (cmd.row_init) begin
			j_q <= i_q + ADDR_W'(1);
		end else if (cmd.cell_step) begin
			j_q <= j_q + ADDR_W'(1);
		end
		j_s1 <= j_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_s1 <= 1'b0;
			head_s1 <= 1'b0;
		end else begin
			cell_s1 <= cmd.cell_step;
			head_s1 <= cmd.row_init;
		end
	end

	always_comb begin
		sum_raw = {1'b0, row_rd_s1} + {1'b0, left_q};
		sum_red = (sum_raw >= {1'b0, PAL_MOD}) ? CNT_W'(sum_raw - {1'b0, PAL_MOD})
			: sum_raw[CNT_W-1:0];
		inc_raw = {1'b0, sum_red} + (CNT_W+1)'(1);
		dif_raw = {1'b0, sum_red} - {1'b0, inner_q};
		dif_fix = dif_raw + {1'b0, PAL_MOD};
		if (char_rd_s1 == ci_q) begin
			cell_val = (inc_raw == {1'b0, PAL_MOD}) ? '0 : inc_raw[CNT_W-1:0];
		end else begin
			cell_val = dif_raw[CNT_W] ? dif_fix[CNT_W-1:0] : dif_raw[CNT_W-1:0];
		end
	end

	assign row_we      = cmd.row_init || cell_s1;
	assign row_wr_addr = cmd.row_init ? i_q : j_s1;
	assign row_wr_data = cmd.row_init ? CNT_W'(1) : cell_val;

	always_ff @(posedge clk) begin
		if (row_we) begin
			row_mem[row_wr_addr] <= row_wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (head_s1) begin
			ci_q <= char_rd_s1;
		end
		if (cmd.row_init) begin
			left_q  <= CNT_W'(1);
			inner_q <= '0;
		end else if (cell_s1) begin
			left_q  <= cell_val;
			inner_q <= row_rd_s1;
		end
	end

	// result register, frees the collector while a result waits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_result || cmd.load_empty) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_result) begin
			out_count_q <= left_q;
			out_ovf_q   <= ovf_q;
		end else if (cmd.load_empty) begin
			out_count_q <= '0;
			out_ovf_q   <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_count = out_count_q;
	assign out_ovf   = out_ovf_q;

	a_row_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.row_init && cell_s1))
		else $error("row store written twice in one cycle");

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_W'(MAX_LEN))
		else $error("string length beyond store depth");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load_result || cmd.load_empty) |-> (!out_valid_q || out_ready))
		else $error("result loaded over a pending result");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && $rose(out_valid_q) |-> out_count_q < PAL_MOD)
		else $error("result count not reduced");

endmodule

`default_nettype wire
